[rtl/core/ske_pkg.sv]
package ske_pkg;

    // Fixed field widths
    localparam int KEYCODE_W = 10;
    localparam int SCAN_W    = 32;
    localparam int INDEX_W   = 6;

    // Request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_REPORT = 2'd1;
    localparam logic [1:0] REQ_GET    = 2'd2;
    localparam logic [1:0] REQ_SET    = 2'd3;

    // Entry types
    localparam logic [1:0] KE_IGNORE = 2'd0;
    localparam logic [1:0] KE_KEY    = 2'd1;
    localparam logic [1:0] KE_SW     = 2'd2;
    localparam logic [1:0] KE_VSW    = 2'd3;

    // Result kinds
    localparam logic [2:0] MSC_SCAN    = 3'd0;
    localparam logic [2:0] KIND_KEY    = 3'd1;
    localparam logic [2:0] KIND_SWITCH = 3'd2;
    localparam logic [2:0] KIND_SYNC   = 3'd3;
    localparam logic [2:0] KIND_REPLY  = 3'd4;

    // Configuration register indexes and reset values
    localparam logic       REG_TABLE_SIZE      = 1'b0;
    localparam logic       REG_UNKNOWN_KEYCODE = 1'b1;
    localparam logic [6:0] TABLE_SIZE_RST      = 7'd0;
    localparam logic [9:0] KEY_UNKNOWN         = 10'd240;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LOAD_CAP,
        ST_SCAN,
        ST_SET_WR,
        ST_SCAN2,
        ST_CAP_RD,
        ST_CAP_WR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]           etype;
        logic [SCAN_W-1:0]    scancode;
        logic [KEYCODE_W-1:0] keycode;
        logic [3:0]           switch_code;
        logic                 switch_state;
    } slot_entry_t;

    typedef struct packed {
        logic [1:0]           req_type;
        logic                 by_index;
        logic [INDEX_W-1:0]   key_index;
        logic [SCAN_W-1:0]    scancode;
        logic [KEYCODE_W-1:0] keycode;
        logic [1:0]           entry_type;
        logic [3:0]           switch_code;
        logic                 switch_state;
        logic [5:0]           slot;
        logic [31:0]          value;
        logic                 autorelease;
    } req_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [KEYCODE_W-1:0] code;
        logic [31:0]          value;
        logic                 found;
        logic [KEYCODE_W-1:0] reply_keycode;
        logic [INDEX_W-1:0]   reply_index;
        logic [SCAN_W-1:0]    reply_scancode;
        logic                 dropped;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic                 wbit;
        logic [KEYCODE_W-1:0] addr;
    } cap_req_t;

endpackage

[rtl/core/ske_slot_mem.sv]
module ske_slot_mem #(
    parameter int ENTRIES = 64
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(ENTRIES)-1:0]  waddr,
    input  ske_pkg::slot_entry_t        wdata,
    input  logic [$clog2(ENTRIES)-1:0]  raddr,
    output ske_pkg::slot_entry_t        rdata
);

    ske_pkg::slot_entry_t mem [ENTRIES];

    // Write one slot, read one slot with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/ske_cap_mem.sv]
module ske_cap_mem #(
    parameter int KEYCODES = 768
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ske_pkg::cap_req_t req,
    output logic              rbit,
    output logic              busy
);

    localparam int KW = $clog2(KEYCODES);
    localparam logic [31:0] LAST_CODE = 32'(KEYCODES - 1);

    logic          cap_mem [KEYCODES];
    logic [KW-1:0] clr_cnt_reg;
    logic [KW-1:0] clr_cnt_next;
    logic          clr_busy_reg;
    logic          clr_busy_next;

    // Advance the clearing sweep after reset
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (32'(clr_cnt_reg) == LAST_CODE)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Clear or write one bit, read one bit with registered data
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            cap_mem[clr_cnt_reg] <= 1'b0;
        end
        else if (req.we)
        begin
            cap_mem[req.addr[KW-1:0]] <= req.wbit;
        end
        rbit <= cap_mem[req.addr[KW-1:0]];
    end

    assign busy = clr_busy_reg;

endmodule

[rtl/core/ske_seq.sv]
module ske_seq #(
    parameter int ENTRIES  = 64,
    parameter int KEYCODES = 768
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ske_pkg::req_t              in_req,
    output logic                       in_stall,
    input  logic [6:0]                 table_size,
    input  logic [9:0]                 unknown_keycode,
    output logic                       mem_we,
    output logic [$clog2(ENTRIES)-1:0] mem_waddr,
    output ske_pkg::slot_entry_t       mem_wdata,
    output logic [$clog2(ENTRIES)-1:0] mem_raddr,
    input  ske_pkg::slot_entry_t       mem_rdata,
    output ske_pkg::cap_req_t          cap_req,
    input  logic                       cap_rbit,
    input  logic                       cap_busy,
    output logic                       out_valid,
    input  logic                       out_stall,
    output ske_pkg::result_t           out_res
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [31:0] ENT_LIM = 32'(ENTRIES);
    localparam logic [31:0] KC_LIM  = 32'(KEYCODES);

    ske_pkg::state_t      state_reg, state_next;
    ske_pkg::req_t        req_reg, req_next;
    logic [CNT_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]     key_cnt_reg, key_cnt_next;
    ske_pkg::slot_entry_t hit_entry_reg, hit_entry_next;
    logic [AW-1:0]        hit_addr_reg, hit_addr_next;
    logic [5:0]           hit_idx_reg, hit_idx_next;
    logic                 found_reg, found_next;
    logic                 dropped_reg, dropped_next;
    logic [2:0]           emit_cnt_reg, emit_cnt_next;
    logic [2:0]           emit_num_reg, emit_num_next;
    logic                 out_valid_reg, out_valid_next;
    ske_pkg::result_t     out_res_reg, out_res_next;

    logic [31:0]          used_w;
    logic [CNT_W-1:0]     used;
    logic                 addr_left;
    ske_pkg::slot_entry_t ent;
    logic                 is_key;
    logic                 scan_match;
    logic                 idx_match;
    logic                 still_match;
    logic                 ev_stop;
    logic                 ev_hit;
    logic                 stop_now;
    logic                 found_now;
    logic                 scan_done;
    logic                 can_emit;
    logic                 emit_last;
    logic                 accept;
    logic                 stall_w;
    logic [31:0]          slot_w;
    logic                 slot_ok;
    logic                 kc_ok;
    logic                 in_kc_ok;
    logic                 unk_ok;
    logic                 old_ok;
    logic [1:0]           rep_type;
    logic                 rep_ar;
    logic [2:0]           rep_num;
    ske_pkg::slot_entry_t load_ent;
    ske_pkg::slot_entry_t set_ent;
    ske_pkg::result_t     emit_res;
    logic                 rep_key;
    logic [9:0]           rep_code;

    // Slots in use, capped at the table depth
    assign used_w    = (32'(table_size) > ENT_LIM) ? ENT_LIM : 32'(table_size);
    assign used      = used_w[CNT_W-1:0];
    assign addr_left = scan_addr_reg < used;

    // Evaluate the entry read in the previous cycle
    assign ent         = mem_rdata;
    assign is_key      = ent.etype == ske_pkg::KE_KEY;
    assign scan_match  = ent.scancode == req_reg.scancode;
    assign idx_match   = 32'(key_cnt_reg) == 32'(req_reg.key_index);
    assign still_match = is_key && (ent.keycode == hit_entry_reg.keycode);

    always_comb
    begin
        ev_stop = 1'b0;
        ev_hit  = 1'b0;
        if (state_reg == ske_pkg::ST_SCAN2)
        begin
            ev_stop = still_match;
            ev_hit  = still_match;
        end
        else if (req_reg.req_type == ske_pkg::REQ_REPORT)
        begin
            ev_stop = scan_match;
            ev_hit  = scan_match;
        end
        else if (req_reg.by_index)
        begin
            ev_stop = is_key && idx_match;
            ev_hit  = is_key && idx_match;
        end
        else
        begin
            ev_stop = scan_match;
            ev_hit  = scan_match && is_key;
        end
    end

    assign stop_now  = pend_reg && ev_stop;
    assign found_now = pend_reg && ev_hit;
    assign scan_done = stop_now || (!pend_reg && !addr_left);

    assign stall_w   = (state_reg != ske_pkg::ST_IDLE) || cap_busy;
    assign accept    = in_valid && !stall_w;
    assign can_emit  = !out_valid_reg || !out_stall;
    assign emit_last = emit_cnt_reg == (emit_num_reg - 3'd1);

    assign slot_w   = 32'(req_reg.slot);
    assign slot_ok  = slot_w < ENT_LIM;
    assign kc_ok    = 32'(req_reg.keycode) < KC_LIM;
    assign in_kc_ok = 32'(in_req.keycode) < KC_LIM;
    assign unk_ok   = 32'(unknown_keycode) < KC_LIM;
    assign old_ok   = 32'(hit_entry_reg.keycode) < KC_LIM;

    // Count the results of a report from the located entry, or as a key when none is found
    always_comb
    begin
        rep_type = found_now ? ent.etype : ske_pkg::KE_KEY;
        rep_ar   = found_now ? req_reg.autorelease : 1'b1;
        case (rep_type)
            ske_pkg::KE_KEY:
            begin
                rep_num = ((req_reg.value != '0) && rep_ar) ? 3'd5 : 3'd3;
            end
            ske_pkg::KE_SW, ske_pkg::KE_VSW:
            begin
                rep_num = 3'd1;
            end
            default:
            begin
                rep_num = 3'd0;
            end
        endcase
    end

    assign load_ent = '{etype: req_reg.entry_type, scancode: req_reg.scancode,
                        keycode: req_reg.keycode, switch_code: req_reg.switch_code,
                        switch_state: req_reg.switch_state};

    always_comb
    begin
        set_ent         = hit_entry_reg;
        set_ent.keycode = req_reg.keycode;
    end

    // Build the result for the current emit step
    assign rep_key  = !found_reg || (hit_entry_reg.etype == ske_pkg::KE_KEY);
    assign rep_code = found_reg ? hit_entry_reg.keycode : unknown_keycode;

    always_comb
    begin
        emit_res      = '0;
        emit_res.last = emit_last;
        if (req_reg.req_type == ske_pkg::REQ_REPORT)
        begin
            emit_res.found = found_reg;
            if (rep_key)
            begin
                case (emit_cnt_reg)
                    3'd0:
                    begin
                        emit_res.kind  = ske_pkg::MSC_SCAN;
                        emit_res.value = req_reg.scancode;
                    end
                    3'd1:
                    begin
                        emit_res.kind  = ske_pkg::KIND_KEY;
                        emit_res.code  = rep_code;
                        emit_res.value = req_reg.value;
                    end
                    3'd3:
                    begin
                        emit_res.kind = ske_pkg::KIND_KEY;
                        emit_res.code = rep_code;
                    end
                    default:
                    begin
                        emit_res.kind = ske_pkg::KIND_SYNC;
                    end
                endcase
            end
            else
            begin
                emit_res.kind  = ske_pkg::KIND_SWITCH;
                emit_res.code  = 10'(hit_entry_reg.switch_code);
                emit_res.value = (hit_entry_reg.etype == ske_pkg::KE_SW)
                               ? 32'(hit_entry_reg.switch_state) : req_reg.value;
            end
        end
        else
        begin
            emit_res.kind  = ske_pkg::KIND_REPLY;
            emit_res.found = found_reg;
            if (found_reg && (req_reg.req_type != ske_pkg::REQ_LOAD))
            begin
                emit_res.reply_keycode  = hit_entry_reg.keycode;
                emit_res.reply_index    = hit_idx_reg;
                emit_res.reply_scancode = hit_entry_reg.scancode;
                emit_res.dropped        = dropped_reg;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ske_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_req.req_type)
                        ske_pkg::REQ_LOAD:
                        begin
                            state_next = ske_pkg::ST_LOAD;
                        end
                        ske_pkg::REQ_SET:
                        begin
                            state_next = in_kc_ok ? ske_pkg::ST_SCAN : ske_pkg::ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ske_pkg::ST_SCAN;
                        end
                    endcase
                end
            end
            ske_pkg::ST_LOAD:
            begin
                state_next = (slot_ok && (req_reg.entry_type == ske_pkg::KE_KEY))
                           ? ske_pkg::ST_LOAD_CAP : ske_pkg::ST_EMIT;
            end
            ske_pkg::ST_LOAD_CAP:
            begin
                state_next = ske_pkg::ST_EMIT;
            end
            ske_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    case (req_reg.req_type)
                        ske_pkg::REQ_REPORT:
                        begin
                            state_next = (rep_num == 3'd0) ? ske_pkg::ST_IDLE
                                                           : ske_pkg::ST_EMIT;
                        end
                        ske_pkg::REQ_SET:
                        begin
                            state_next = found_now ? ske_pkg::ST_SET_WR : ske_pkg::ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ske_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            ske_pkg::ST_SET_WR:
            begin
                state_next = ske_pkg::ST_SCAN2;
            end
            ske_pkg::ST_SCAN2:
            begin
                if (scan_done)
                begin
                    state_next = (!found_now && old_ok) ? ske_pkg::ST_CAP_RD
                                                        : ske_pkg::ST_EMIT;
                end
            end
            ske_pkg::ST_CAP_RD:
            begin
                state_next = ske_pkg::ST_CAP_WR;
            end
            ske_pkg::ST_CAP_WR:
            begin
                state_next = ske_pkg::ST_EMIT;
            end
            ske_pkg::ST_EMIT:
            begin
                if (can_emit && emit_last)
                begin
                    state_next = ske_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ske_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and output register
    always_comb
    begin
        req_next       = req_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = pend_reg;
        rd_addr_next   = rd_addr_reg;
        key_cnt_next   = key_cnt_reg;
        hit_entry_next = hit_entry_reg;
        hit_addr_next  = hit_addr_reg;
        hit_idx_next   = hit_idx_reg;
        found_next     = found_reg;
        dropped_next   = dropped_reg;
        emit_cnt_next  = emit_cnt_reg;
        emit_num_next  = emit_num_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_res_next   = out_res_reg;
        mem_we         = 1'b0;
        mem_waddr      = hit_addr_reg;
        mem_wdata      = set_ent;
        cap_req        = '0;

        case (state_reg)
            ske_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next       = in_req;
                    scan_addr_next = '0;
                    pend_next      = 1'b0;
                    key_cnt_next   = '0;
                    found_next     = 1'b0;
                    dropped_next   = 1'b0;
                    emit_cnt_next  = '0;
                    emit_num_next  = 3'd1;
                end
            end
            ske_pkg::ST_LOAD:
            begin
                found_next = slot_ok;
                if (slot_ok)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_w[AW-1:0];
                    mem_wdata = load_ent;
                    if ((req_reg.entry_type == ske_pkg::KE_KEY) && kc_ok)
                    begin
                        cap_req.we   = 1'b1;
                        cap_req.wbit = 1'b1;
                        cap_req.addr = req_reg.keycode;
                    end
                end
            end
            ske_pkg::ST_LOAD_CAP:
            begin
                cap_req.we   = unk_ok;
                cap_req.wbit = 1'b1;
                cap_req.addr = unknown_keycode;
            end
            ske_pkg::ST_SCAN, ske_pkg::ST_SCAN2:
            begin
                // Issue the next read unless the scan stops here
                pend_next = !stop_now && addr_left;
                if (!stop_now && addr_left)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                    rd_addr_next   = scan_addr_reg[AW-1:0];
                end
                if (state_reg == ske_pkg::ST_SCAN)
                begin
                    if (pend_reg && !ev_stop && is_key)
                    begin
                        key_cnt_next = key_cnt_reg + 1'b1;
                    end
                    if (found_now)
                    begin
                        hit_entry_next = ent;
                        hit_addr_next  = rd_addr_reg;
                        hit_idx_next   = 6'(key_cnt_reg);
                    end
                    if (scan_done)
                    begin
                        found_next    = found_now;
                        emit_num_next = (req_reg.req_type == ske_pkg::REQ_REPORT)
                                      ? rep_num : 3'd1;
                    end
                end
                else if (scan_done)
                begin
                    dropped_next = !found_now && old_ok;
                end
            end
            ske_pkg::ST_SET_WR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = hit_addr_reg;
                mem_wdata      = set_ent;
                cap_req.we     = 1'b1;
                cap_req.wbit   = 1'b1;
                cap_req.addr   = req_reg.keycode;
                scan_addr_next = '0;
                pend_next      = 1'b0;
            end
            ske_pkg::ST_CAP_RD:
            begin
                cap_req.addr = hit_entry_reg.keycode;
            end
            ske_pkg::ST_CAP_WR:
            begin
                // Drop the bit only when it is still set
                cap_req.we   = cap_rbit;
                cap_req.wbit = 1'b0;
                cap_req.addr = hit_entry_reg.keycode;
            end
            ske_pkg::ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_res_next   = emit_res;
                    out_valid_next = 1'b1;
                    emit_cnt_next  = emit_cnt_reg + 3'd1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ske_pkg::ST_IDLE;
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
            key_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            emit_num_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_addr_reg <= scan_addr_next;
            pend_reg      <= pend_next;
            key_cnt_reg   <= key_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            emit_num_reg  <= emit_num_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rd_addr_reg   <= rd_addr_next;
        hit_entry_reg <= hit_entry_next;
        hit_addr_reg  <= hit_addr_next;
        hit_idx_reg   <= hit_idx_next;
        found_reg     <= found_next;
        dropped_reg   <= dropped_next;
        out_res_reg   <= out_res_next;
    end

    assign mem_raddr = scan_addr_reg[AW-1:0];
    assign in_stall  = stall_w;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

[rtl/core/scancode_keymap_engine_top.sv]
// Scancode to keycode table with key capability bitmap.
//
// Input channel (in_valid / in_stall) takes one request per transfer: load a
// slot, report a scancode, or get / set the keycode of a key entry. Output
// channel (out_valid / out_stall) returns the results of a request in order,
// one per transfer; last_result marks the final one. A report on an ignore
// entry returns nothing. Registers are to be written on cfg_we only while
// idle; the user is bound to this, the block does not enforce it.
//
// Report and get scan the slots in use through the slot memory, one slot per
// cycle. A set that locates its entry rewrites it, scans the slots a second
// time and updates the capability memory. One request is in flight at a
// time; the next is taken once the last result sits in the output register.
//
// After reset the capability memory is swept clear, one keycode per cycle;
// in_stall stays high meanwhile. A stalled output holds its result and the
// request sequencer waits on it before emitting the next result.
module scancode_keymap_engine_top #(
    parameter int ENTRIES  = 64,
    parameter int KEYCODES = 768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        by_index,
    input  logic [5:0]  key_index,
    input  logic [31:0] scancode,
    input  logic [9:0]  keycode,
    input  logic [1:0]  entry_type,
    input  logic [3:0]  switch_code,
    input  logic        switch_state,
    input  logic [5:0]  slot,
    input  logic [31:0] value,
    input  logic        autorelease,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [9:0]  result_code,
    output logic [31:0] result_value,
    output logic        found,
    output logic [9:0]  reply_keycode,
    output logic [5:0]  reply_index,
    output logic [31:0] reply_scancode,
    output logic        old_code_dropped,
    output logic        last_result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata
);

    localparam int AW = $clog2(ENTRIES);

    logic [6:0]           table_size_reg;
    logic [6:0]           table_size_next;
    logic [9:0]           unknown_keycode_reg;
    logic [9:0]           unknown_keycode_next;
    ske_pkg::req_t        in_req;
    ske_pkg::result_t     out_res;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    ske_pkg::slot_entry_t mem_wdata;
    logic [AW-1:0]        mem_raddr;
    ske_pkg::slot_entry_t mem_rdata;
    ske_pkg::cap_req_t    cap_req;
    logic                 cap_rbit;
    logic                 cap_busy;

    // Configuration registers
    always_comb
    begin
        table_size_next      = table_size_reg;
        unknown_keycode_next = unknown_keycode_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ske_pkg::REG_TABLE_SIZE:
                begin
                    table_size_next = cfg_wdata[6:0];
                end
                ske_pkg::REG_UNKNOWN_KEYCODE:
                begin
                    unknown_keycode_next = cfg_wdata;
                end
                default:
                begin
                    table_size_next = table_size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg      <= ske_pkg::TABLE_SIZE_RST;
            unknown_keycode_reg <= ske_pkg::KEY_UNKNOWN;
        end
        else
        begin
            table_size_reg      <= table_size_next;
            unknown_keycode_reg <= unknown_keycode_next;
        end
    end

    // Gather the request fields
    assign in_req = '{req_type: req_type, by_index: by_index, key_index: key_index,
                      scancode: scancode, keycode: keycode, entry_type: entry_type,
                      switch_code: switch_code, switch_state: switch_state,
                      slot: slot, value: value, autorelease: autorelease};

    ske_slot_mem #(
        .ENTRIES (ENTRIES)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ske_cap_mem #(
        .KEYCODES (KEYCODES)
    ) u_cap_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cap_req),
        .rbit  (cap_rbit),
        .busy  (cap_busy)
    );

    ske_seq #(
        .ENTRIES  (ENTRIES),
        .KEYCODES (KEYCODES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_req          (in_req),
        .in_stall        (in_stall),
        .table_size      (table_size_reg),
        .unknown_keycode (unknown_keycode_reg),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata),
        .cap_req         (cap_req),
        .cap_rbit        (cap_rbit),
        .cap_busy        (cap_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_res         (out_res)
    );

    // Spread the result onto the output ports
    assign result_kind      = out_res.kind;
    assign result_code      = out_res.code;
    assign result_value     = out_res.value;
    assign found            = out_res.found;
    assign reply_keycode    = out_res.reply_keycode;
    assign reply_index      = out_res.reply_index;
    assign reply_scancode   = out_res.reply_scancode;
    assign old_code_dropped = out_res.dropped;
    assign last_result      = out_res.last;

`ifndef SYNTHESIS
    // One request at a time: the cycle after a transfer in, the input stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in progress");

    // A reply is always the only and final result of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == ske_pkg::KIND_REPLY) |-> last_result)
        else $error("reply not marked as last result");

    // A dropped capability bit only comes with a located set reply
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && old_code_dropped |-> found && (result_kind == ske_pkg::KIND_REPLY))
        else $error("dropped flag on a result that is not a found reply");
`endif

endmodule
